// ===== rtl/ecpfpu_pkg.sv =====
// Shared types and constants of the prime field elliptic curve point unit.
// Used by ecpfpu_alu and ecc_prime_field_point_unit; depends on nothing.
package ecpfpu_pkg;

   typedef enum logic [1:0] {
      FUNC_ADD   = 2'd0,
      FUNC_DBL   = 2'd1,
      FUNC_MUL   = 2'd2,
      FUNC_CHECK = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SUB,
      ALU_MUL,
      ALU_DIV
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_ctl_type;

   localparam logic [1:0] CSR_MODULUS = 2'd0;
   localparam logic [1:0] CSR_COEF_A  = 2'd1;
   localparam logic [1:0] CSR_COEF_B  = 2'd2;

   localparam int RESET_MODULUS = 17;
   localparam int RESET_COEF_A  = 1;
   localparam int RESET_COEF_B  = 6;

   typedef enum logic [5:0] {
      ST_IDLE,
      ST_RED_X1, ST_RED_Y1, ST_RED_X2, ST_RED_Y2, ST_RED_A, ST_RED_B,
      ST_DISPATCH,
      ST_ADD_START, ST_ADD_SUM, ST_ADD_T1, ST_ADD_T2,
      ST_INV_TEST, ST_INV_DIV, ST_INV_MUL, ST_INV_SUB,
      ST_ADD_LAM, ST_ADD_SQ, ST_ADD_X1, ST_ADD_X2, ST_ADD_Y1, ST_ADD_Y2, ST_ADD_Y3,
      ST_DBL_START, ST_DBL_SQ, ST_DBL_N1, ST_DBL_N2, ST_DBL_N3, ST_DBL_DEN,
      ST_DBL_LAM, ST_DBL_L2, ST_DBL_X1, ST_DBL_X2, ST_DBL_Y1, ST_DBL_Y2, ST_DBL_Y3,
      ST_MUL_TEST,
      ST_CHK_START, ST_CHK_L, ST_CHK_X2, ST_CHK_X3, ST_CHK_AX, ST_CHK_S1, ST_CHK_S2,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/ecpfpu_alu.sv =====
// Shared modular arithmetic unit: add and subtract finish in the cycle after start,
// multiply and integer divide one bit per cycle. Depends on ecpfpu_pkg.
module ecpfpu_alu #(
   parameter int W = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  ecpfpu_pkg::alu_ctl_type  ctl,
   input  logic [W-1:0]             opa,
   input  logic [W-1:0]             opb,
   input  logic [W-1:0]             modulus,
   output logic                     done,
   output logic [W-1:0]             res,
   output logic [W-1:0]             quo
);
   import ecpfpu_pkg::*;

   localparam int CW = $clog2(W + 1);

   alu_op_type     op_ff, op_in;
   logic [W-1:0]   a_ff, a_in;
   logic [W-1:0]   b_ff, b_in;
   logic [W-1:0]   m_ff, m_in;
   logic [W-1:0]   acc_ff, acc_in;
   logic [W-1:0]   sh_ff, sh_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           run_ff, run_in;
   logic           done_ff, done_in;

   logic [W-1:0]   add_res, sub_res, mul_dbl, mul_next;
   logic [W:0]     sub_d, div_t, div_rem;
   logic           div_ge;

   function automatic logic [W-1:0] mod_add(input logic [W-1:0] x, input logic [W-1:0] y,
                                            input logic [W-1:0] mm);
      logic [W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, mm}) begin
         s = s - {1'b0, mm};
      end
      return s[W-1:0];
   endfunction

   always_comb begin
      add_res = mod_add(opa, opb, modulus);
      sub_d = {1'b0, opa} - {1'b0, opb};
      if (opa < opb) begin
         sub_d = sub_d + {1'b0, modulus};
      end
      sub_res = sub_d[W-1:0];
      mul_dbl = mod_add(acc_ff, acc_ff, m_ff);
      mul_next = sh_ff[W-1] ? mod_add(mul_dbl, a_ff, m_ff) : mul_dbl;
      div_t = {acc_ff, sh_ff[W-1]};
      div_ge = (div_t >= {1'b0, b_ff});
      div_rem = div_ge ? (div_t - {1'b0, b_ff}) : div_t;
   end

   always_comb begin
      op_in = op_ff;
      a_in = a_ff;
      b_in = b_ff;
      m_in = m_ff;
      acc_in = acc_ff;
      sh_in = sh_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (ctl.start && !run_ff) begin
         op_in = ctl.op;
         a_in = opa;
         b_in = opb;
         m_in = modulus;
         cnt_in = CW'(W);
         unique case (ctl.op)
            ALU_ADD: begin
               acc_in = add_res;
               done_in = 1'b1;
            end
            ALU_SUB: begin
               acc_in = sub_res;
               done_in = 1'b1;
            end
            ALU_MUL: begin
               acc_in = '0;
               sh_in = opb;
               run_in = 1'b1;
            end
            ALU_DIV: begin
               acc_in = '0;
               sh_in = opa;
               run_in = 1'b1;
            end
         endcase
      end else if (run_ff) begin
         cnt_in = cnt_ff - CW'(1);
         if (op_ff == ALU_MUL) begin
            acc_in = mul_next;
            sh_in = sh_ff << 1;
         end else begin
            acc_in = div_rem[W-1:0];
            sh_in = {sh_ff[W-2:0], div_ge};
         end
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
      end
      op_ff <= op_in;
      a_ff <= a_in;
      b_ff <= b_in;
      m_ff <= m_in;
      acc_ff <= acc_in;
      sh_ff <= sh_in;
      cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign res = acc_ff;
   assign quo = sh_ff;

endmodule

// ===== rtl/ecc_prime_field_point_unit.sv =====
// Affine point unit for y^2 = x^3 + a*x + b over a prime field: top level.
// Depends on ecpfpu_pkg and ecpfpu_alu.
//
// A command word is taken on a rising edge where start is high and busy is
// low; busy then stays high until the result has been formed. The command
// selects point addition, point doubling, double-and-add scalar
// multiplication of the first point, or an on-curve check of the first point.
// The result word appears on the rsp_ ports, marked by rsp_strobe for exactly one
// cycle, in the first cycle in which busy is low again; the receiver
// cannot stall it, and the next command may be taken in that same cycle.
// The csr_ channel writes the modulus and the two curve coefficients; it is
// always ready, and writes belong in periods when busy is low.
// All arithmetic goes through the single shared arithmetic unit, in which
// multiply and divide work bit-serially. Every command first reduces its six
// operands (both points and both coefficients) with integer divides by the
// modulus. An inversion runs extended Euclid steps, each a divide, a multiply
// and a subtract. An add or a double runs at most one inversion; a scalar
// multiply runs up to 2*SCALAR_BITS adds and doubles. The on-curve check
// needs no inversion.
// Synchronous reset returns the sequencer to idle, drops the strobe and
// loads the modulus 17 and coefficients 1 and 6.
module ecc_prime_field_point_unit #(
   parameter int FIELD_BITS  = 16,
   parameter int SCALAR_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_func,
   input  logic [FIELD_BITS-1:0]   req_x_one,
   input  logic [FIELD_BITS-1:0]   req_y_one,
   input  logic                    req_inf_one,
   input  logic [FIELD_BITS-1:0]   req_x_two,
   input  logic [FIELD_BITS-1:0]   req_y_two,
   input  logic                    req_inf_two,
   input  logic [SCALAR_BITS-1:0]  req_scalar,
   output logic                    rsp_strobe,
   output logic [FIELD_BITS-1:0]   rsp_res_x,
   output logic [FIELD_BITS-1:0]   rsp_res_y,
   output logic                    rsp_res_inf,
   output logic                    rsp_on_curve,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [FIELD_BITS-1:0]   csr_wdata
);
   import ecpfpu_pkg::*;

   localparam int W = FIELD_BITS;

   state_type               state_ff, state_in;
   logic                    issued_ff, issued_in;
   func_type                func_ff, func_in;
   logic [SCALAR_BITS-1:0]  k_ff, k_in;
   logic [W-1:0]            ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   logic                    ainf_ff, ainf_in, binf_ff, binf_in;
   logic [W-1:0]            ca_ff, ca_in, cb_ff, cb_in;
   logic [W-1:0]            t1_ff, t1_in, t2_ff, t2_in, lam_ff, lam_in;
   logic [W-1:0]            u_ff, u_in, v_ff, v_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [W-1:0]            qd_ff, qd_in;
   logic                    inv_dbl_ff, inv_dbl_in;
   logic                    dbl_to_a_ff, dbl_to_a_in;
   logic                    chk_ff, chk_in;
   logic [W-1:0]            mod_ff, mod_in, coa_ff, coa_in, cob_ff, cob_in;
   logic                    strobe_ff, strobe_in;
   logic [W-1:0]            rx_ff, rx_in, ry_ff, ry_in;
   logic                    rinf_ff, rinf_in, rchk_ff, rchk_in;

   alu_ctl_type             alu_ctl;
   alu_op_type              alu_op;
   logic                    alu_state;
   logic [W-1:0]            alu_a, alu_b, alu_res, alu_quo;
   logic                    alu_done;
   logic                    mod_small;
   logic [W-1:0]            red_val;
   state_type               after_add, after_dbl;

   ecpfpu_alu #(
      .W (W)
   ) u_alu (
      .clock   (clock),
      .reset   (reset),
      .ctl     (alu_ctl),
      .opa     (alu_a),
      .opb     (alu_b),
      .modulus (mod_ff),
      .done    (alu_done),
      .res     (alu_res),
      .quo     (alu_quo)
   );

   assign alu_ctl = {alu_state && !issued_ff, alu_op};
   assign mod_small = (mod_ff < W'(2));
   assign red_val = mod_small ? '0 : alu_res;
   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      mod_in = mod_ff;
      coa_in = coa_ff;
      cob_in = cob_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MODULUS: mod_in = csr_wdata;
            CSR_COEF_A:  coa_in = csr_wdata;
            CSR_COEF_B:  cob_in = csr_wdata;
            default:     mod_in = mod_ff;
         endcase
      end
   end

   always_comb begin
      after_add = (func_ff == FUNC_MUL) ? ST_DBL_START : ST_FINISH;
      if (dbl_to_a_ff) begin
         after_dbl = after_add;
      end else begin
         after_dbl = (func_ff == FUNC_MUL) ? ST_MUL_TEST : ST_FINISH;
      end
   end

   always_comb begin
      state_in = state_ff;
      func_in = func_ff;
      k_in = k_ff;
      ax_in = ax_ff;
      ay_in = ay_ff;
      bx_in = bx_ff;
      by_in = by_ff;
      ainf_in = ainf_ff;
      binf_in = binf_ff;
      ca_in = ca_ff;
      cb_in = cb_ff;
      t1_in = t1_ff;
      t2_in = t2_ff;
      lam_in = lam_ff;
      u_in = u_ff;
      v_in = v_ff;
      c0_in = c0_ff;
      c1_in = c1_ff;
      qd_in = qd_ff;
      inv_dbl_in = inv_dbl_ff;
      dbl_to_a_in = dbl_to_a_ff;
      chk_in = chk_ff;
      strobe_in = 1'b0;
      rx_in = rx_ff;
      ry_in = ry_ff;
      rinf_in = rinf_ff;
      rchk_in = rchk_ff;
      alu_state = 1'b0;
      alu_op = ALU_ADD;
      alu_a = '0;
      alu_b = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in = func_type'(req_func);
               ax_in = req_x_one;
               ay_in = req_y_one;
               ainf_in = req_inf_one;
               bx_in = req_x_two;
               by_in = req_y_two;
               binf_in = req_inf_two;
               k_in = req_scalar;
               chk_in = 1'b0;
               dbl_to_a_in = 1'b0;
               state_in = ST_RED_X1;
            end
         end
         ST_RED_X1: begin
            alu_state = 1'b1;
            alu_op = ALU_DIV;
            alu_a = ax_ff;
            alu_b = mod_ff;
            if (alu_done) begin
               ax_in = red_val;
               state_in = ST_RED_Y1;
            end
         end
         ST_RED_Y1: begin
            alu_state = 1'b1;
            alu_op = ALU_DIV;
            alu_a = ay_ff;
            alu_b = mod_ff;
            if (alu_done) begin
               ay_in = red_val;
               state_in = ST_RED_X2;
            end
         end
         ST_RED_X2: begin
            alu_state = 1'b1;
            alu_op = ALU_DIV;
            alu_a = bx_ff;
            alu_b = mod_ff;
            if (alu_done) begin
               bx_in = red_val;
               state_in = ST_RED_Y2;
            end
         end
         ST_RED_Y2: begin
            alu_state = 1'b1;
            alu_op = ALU_DIV;
            alu_a = by_ff;
            alu_b = mod_ff;
            if (alu_done) begin
               by_in = red_val;
               state_in = ST_RED_A;
            end
         end
         ST_RED_A: begin
            alu_state = 1'b1;
            alu_op = ALU_DIV;
            alu_a = coa_ff;
            alu_b = mod_ff;
            if (alu_done) begin
               ca_in = red_val;
               state_in = ST_RED_B;
            end
         end
         ST_RED_B: begin
            alu_state = 1'b1;
            alu_op = ALU_DIV;
            alu_a = cob_ff;
            alu_b = mod_ff;
            if (alu_done) begin
               cb_in = red_val;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (func_ff != FUNC_ADD) begin
               bx_in = ax_ff;
               by_in = ay_ff;
               binf_in = ainf_ff;
               ainf_in = 1'b1;
            end
            unique case (func_ff)
               FUNC_ADD:   state_in = ST_ADD_START;
               FUNC_DBL:   state_in = ST_DBL_START;
               FUNC_MUL:   state_in = ST_MUL_TEST;
               FUNC_CHECK: state_in = ST_CHK_START;
            endcase
         end
         ST_MUL_TEST: begin
            if (k_ff == '0) begin
               state_in = ST_FINISH;
            end else if (k_ff[0]) begin
               state_in = ST_ADD_START;
            end else begin
               state_in = ST_DBL_START;
            end
         end
         ST_ADD_START: begin
            if (ainf_ff) begin
               ax_in = bx_ff;
               ay_in = by_ff;
               ainf_in = binf_ff;
               state_in = after_add;
            end else if (binf_ff) begin
               state_in = after_add;
            end else begin
               state_in = ST_ADD_SUM;
            end
         end
         ST_ADD_SUM: begin
            alu_state = 1'b1;
            alu_op = ALU_ADD;
            alu_a = ay_ff;
            alu_b = by_ff;
            if (alu_done) begin
               if (ax_ff == bx_ff && alu_res == '0) begin
                  ainf_in = 1'b1;
                  state_in = after_add;
               end else if (ax_ff == bx_ff && ay_ff == by_ff) begin
                  dbl_to_a_in = 1'b1;
                  state_in = ST_DBL_START;
               end else begin
                  state_in = ST_ADD_T1;
               end
            end
         end
         ST_ADD_T1: begin
            alu_state = 1'b1;
            alu_op = ALU_SUB;
            alu_a = by_ff;
            alu_b = ay_ff;
            if (alu_done) begin
               t1_in = alu_res;
               state_in = ST_ADD_T2;
            end
         end
         ST_ADD_T2: begin
            alu_state = 1'b1;
            alu_op = ALU_SUB;
            alu_a = bx_ff;
            alu_b = ax_ff;
            if (alu_done) begin
               u_in = alu_res;
               v_in = mod_ff;
               c0_in = '0;
               c1_in = W'(1);
               inv_dbl_in = 1'b0;
               state_in = ST_INV_TEST;
            end
         end
         ST_INV_TEST: begin
            if (u_ff > W'(1) && v_ff != '0) begin
               state_in = ST_INV_DIV;
            end else begin
               state_in = inv_dbl_ff ? ST_DBL_LAM : ST_ADD_LAM;
            end
         end
         ST_INV_DIV: begin
            alu_state = 1'b1;
            alu_op = ALU_DIV;
            alu_a = u_ff;
            alu_b = v_ff;
            if (alu_done) begin
               qd_in = alu_quo;
               u_in = v_ff;
               v_in = alu_res;
               state_in = ST_INV_MUL;
            end
         end
         ST_INV_MUL: begin
            alu_state = 1'b1;
            alu_op = ALU_MUL;
            alu_a = qd_ff;
            alu_b = c0_ff;
            if (alu_done) begin
               qd_in = alu_res;
               state_in = ST_INV_SUB;
            end
         end
         ST_INV_SUB: begin
            alu_state = 1'b1;
            alu_op = ALU_SUB;
            alu_a = c1_ff;
            alu_b = qd_ff;
            if (alu_done) begin
               c0_in = alu_res;
               c1_in = c0_ff;
               state_in = ST_INV_TEST;
            end
         end
         ST_ADD_LAM: begin
            alu_state = 1'b1;
            alu_op = ALU_MUL;
            alu_a = t1_ff;
            alu_b = c1_ff;
            if (alu_done) begin
               lam_in = alu_res;
               state_in = ST_ADD_SQ;
            end
         end
         ST_ADD_SQ: begin
            alu_state = 1'b1;
            alu_op = ALU_MUL;
            alu_a = lam_ff;
            alu_b = lam_ff;
            if (alu_done) begin
               t1_in = alu_res;
               state_in = ST_ADD_X1;
            end
         end
         ST_ADD_X1: begin
            alu_state = 1'b1;
            alu_op = ALU_SUB;
            alu_a = t1_ff;
            alu_b = ax_ff;
            if (alu_done) begin
               t1_in = alu_res;
               state_in = ST_ADD_X2;
            end
         end
         ST_ADD_X2: begin
            alu_state = 1'b1;
            alu_op = ALU_SUB;
            alu_a = t1_ff;
            alu_b = bx_ff;
            if (alu_done) begin
               t1_in = alu_res;
               state_in = ST_ADD_Y1;
            end
         end
         ST_ADD_Y1: begin
            alu_state = 1'b1;
            alu_op = ALU_SUB;
            alu_a = ax_ff;
            alu_b = t1_ff;
            if (alu_done) begin
               t2_in = alu_res;
               state_in = ST_ADD_Y2;
            end
         end
         ST_ADD_Y2: begin
            alu_state = 1'b1;
            alu_op = ALU_MUL;
            alu_a = lam_ff;
            alu_b = t2_ff;
            if (alu_done) begin
               t2_in = alu_res;
               state_in = ST_ADD_Y3;
            end
         end
         ST_ADD_Y3: begin
            alu_state = 1'b1;
            alu_op = ALU_SUB;
            alu_a = t2_ff;
            alu_b = ay_ff;
            if (alu_done) begin
               ay_in = alu_res;
               ax_in = t1_ff;
               ainf_in = 1'b0;
               state_in = after_add;
            end
         end
         ST_DBL_START: begin
            if (binf_ff || by_ff == '0) begin
               if (dbl_to_a_ff) begin
                  ainf_in = 1'b1;
               end else begin
                  binf_in = 1'b1;
                  if (func_ff == FUNC_MUL) begin
                     k_in = k_ff >> 1;
                  end
               end
               dbl_to_a_in = 1'b0;
               state_in = after_dbl;
            end else begin
               state_in = ST_DBL_SQ;
            end
         end
         ST_DBL_SQ: begin
            alu_state = 1'b1;
            alu_op = ALU_MUL;
            alu_a = bx_ff;
            alu_b = bx_ff;
            if (alu_done) begin
               t1_in = alu_res;
               state_in = ST_DBL_N1;
            end
         end
         ST_DBL_N1: begin
            alu_state = 1'b1;
            alu_op = ALU_ADD;
            alu_a = t1_ff;
            alu_b = t1_ff;
            if (alu_done) begin
               t2_in = alu_res;
               state_in = ST_DBL_N2;
            end
         end
         ST_DBL_N2: begin
            alu_state = 1'b1;
            alu_op = ALU_ADD;
            alu_a = t2_ff;
            alu_b = t1_ff;
            if (alu_done) begin
               t2_in = alu_res;
               state_in = ST_DBL_N3;
            end
         end
         ST_DBL_N3: begin
            alu_state = 1'b1;
            alu_op = ALU_ADD;
            alu_a = t2_ff;
            alu_b = ca_ff;
            if (alu_done) begin
               t2_in = alu_res;
               state_in = ST_DBL_DEN;
            end
         end
         ST_DBL_DEN: begin
            alu_state = 1'b1;
            alu_op = ALU_ADD;
            alu_a = by_ff;
            alu_b = by_ff;
            if (alu_done) begin
               u_in = alu_res;
               v_in = mod_ff;
               c0_in = '0;
               c1_in = W'(1);
               inv_dbl_in = 1'b1;
               state_in = ST_INV_TEST;
            end
         end
         ST_DBL_LAM: begin
            alu_state = 1'b1;
            alu_op = ALU_MUL;
            alu_a = t2_ff;
            alu_b = c1_ff;
            if (alu_done) begin
               lam_in = alu_res;
               state_in = ST_DBL_L2;
            end
         end
         ST_DBL_L2: begin
            alu_state = 1'b1;
            alu_op = ALU_MUL;
            alu_a = lam_ff;
            alu_b = lam_ff;
            if (alu_done) begin
               t1_in = alu_res;
               state_in = ST_DBL_X1;
            end
         end
         ST_DBL_X1: begin
            alu_state = 1'b1;
            alu_op = ALU_SUB;
            alu_a = t1_ff;
            alu_b = bx_ff;
            if (alu_done) begin
               t1_in = alu_res;
               state_in = ST_DBL_X2;
            end
         end
         ST_DBL_X2: begin
            alu_state = 1'b1;
            alu_op = ALU_SUB;
            alu_a = t1_ff;
            alu_b = bx_ff;
            if (alu_done) begin
               t1_in = alu_res;
               state_in = ST_DBL_Y1;
            end
         end
         ST_DBL_Y1: begin
            alu_state = 1'b1;
            alu_op = ALU_SUB;
            alu_a = bx_ff;
            alu_b = t1_ff;
            if (alu_done) begin
               t2_in = alu_res;
               state_in = ST_DBL_Y2;
            end
         end
         ST_DBL_Y2: begin
            alu_state = 1'b1;
            alu_op = ALU_MUL;
            alu_a = lam_ff;
            alu_b = t2_ff;
            if (alu_done) begin
               t2_in = alu_res;
               state_in = ST_DBL_Y3;
            end
         end
         ST_DBL_Y3: begin
            alu_state = 1'b1;
            alu_op = ALU_SUB;
            alu_a = t2_ff;
            alu_b = by_ff;
            if (alu_done) begin
               if (dbl_to_a_ff) begin
                  ax_in = t1_ff;
                  ay_in = alu_res;
                  ainf_in = 1'b0;
               end else begin
                  bx_in = t1_ff;
                  by_in = alu_res;
                  binf_in = 1'b0;
                  if (func_ff == FUNC_MUL) begin
                     k_in = k_ff >> 1;
                  end
               end
               dbl_to_a_in = 1'b0;
               state_in = after_dbl;
            end
         end
         ST_CHK_START: begin
            if (binf_ff) begin
               chk_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_CHK_L;
            end
         end
         ST_CHK_L: begin
            alu_state = 1'b1;
            alu_op = ALU_MUL;
            alu_a = by_ff;
            alu_b = by_ff;
            if (alu_done) begin
               lam_in = alu_res;
               state_in = ST_CHK_X2;
            end
         end
         ST_CHK_X2: begin
            alu_state = 1'b1;
            alu_op = ALU_MUL;
            alu_a = bx_ff;
            alu_b = bx_ff;
            if (alu_done) begin
               t1_in = alu_res;
               state_in = ST_CHK_X3;
            end
         end
         ST_CHK_X3: begin
            alu_state = 1'b1;
            alu_op = ALU_MUL;
            alu_a = t1_ff;
            alu_b = bx_ff;
            if (alu_done) begin
               t1_in = alu_res;
               state_in = ST_CHK_AX;
            end
         end
         ST_CHK_AX: begin
            alu_state = 1'b1;
            alu_op = ALU_MUL;
            alu_a = ca_ff;
            alu_b = bx_ff;
            if (alu_done) begin
               t2_in = alu_res;
               state_in = ST_CHK_S1;
            end
         end
         ST_CHK_S1: begin
            alu_state = 1'b1;
            alu_op = ALU_ADD;
            alu_a = t1_ff;
            alu_b = t2_ff;
            if (alu_done) begin
               t1_in = alu_res;
               state_in = ST_CHK_S2;
            end
         end
         ST_CHK_S2: begin
            alu_state = 1'b1;
            alu_op = ALU_ADD;
            alu_a = t1_ff;
            alu_b = cb_ff;
            if (alu_done) begin
               chk_in = (alu_res == lam_ff);
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            strobe_in = 1'b1;
            rchk_in = 1'b0;
            unique case (func_ff)
               FUNC_CHECK: begin
                  rx_in = '0;
                  ry_in = '0;
                  rinf_in = 1'b0;
                  rchk_in = chk_ff;
               end
               FUNC_DBL: begin
                  rx_in = binf_ff ? '0 : bx_ff;
                  ry_in = binf_ff ? '0 : by_ff;
                  rinf_in = binf_ff;
               end
               FUNC_ADD, FUNC_MUL: begin
                  rx_in = ainf_ff ? '0 : ax_ff;
                  ry_in = ainf_ff ? '0 : ay_ff;
                  rinf_in = ainf_ff;
               end
            endcase
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         issued_ff <= 1'b0;
         strobe_ff <= 1'b0;
         mod_ff <= W'(RESET_MODULUS);
         coa_ff <= W'(RESET_COEF_A);
         cob_ff <= W'(RESET_COEF_B);
      end else begin
         state_ff <= state_in;
         issued_ff <= issued_in;
         strobe_ff <= strobe_in;
         mod_ff <= mod_in;
         coa_ff <= coa_in;
         cob_ff <= cob_in;
      end
      func_ff <= func_in;
      k_ff <= k_in;
      ax_ff <= ax_in;
      ay_ff <= ay_in;
      bx_ff <= bx_in;
      by_ff <= by_in;
      ainf_ff <= ainf_in;
      binf_ff <= binf_in;
      ca_ff <= ca_in;
      cb_ff <= cb_in;
      t1_ff <= t1_in;
      t2_ff <= t2_in;
      lam_ff <= lam_in;
      u_ff <= u_in;
      v_ff <= v_in;
      c0_ff <= c0_in;
      c1_ff <= c1_in;
      qd_ff <= qd_in;
      inv_dbl_ff <= inv_dbl_in;
      dbl_to_a_ff <= dbl_to_a_in;
      chk_ff <= chk_in;
      rx_ff <= rx_in;
      ry_ff <= ry_in;
      rinf_ff <= rinf_in;
      rchk_ff <= rchk_in;
   end

   assign issued_in = alu_state && !alu_done;
   assign rsp_strobe = strobe_ff;
   assign rsp_res_x = rx_ff;
   assign rsp_res_y = ry_ff;
   assign rsp_res_inf = rinf_ff;
   assign rsp_on_curve = rchk_ff;

`ifndef SYNTHESIS
   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_FINISH))
      else $error("result strobe without a finished command");

   a_alu_done_issued: assert property (@(posedge clock) disable iff (reset)
      alu_done |-> issued_ff)
      else $error("arithmetic unit finished without an issued operation");

   a_check_only_func: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_on_curve |-> func_ff == FUNC_CHECK)
      else $error("on-curve flag set for a point operation");

   a_inf_zero_coords: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_res_inf |-> rsp_res_x == '0 && rsp_res_y == '0)
      else $error("point at infinity carries nonzero coordinates");
`endif

endmodule

// ===== tb/ecpfpu_checker.sv =====
// Checker for the prime field point unit: watches command, result and csr words,
// predicts each result with its own copy of the curve registers and compares.
// Depends on ecpfpu_pkg.
`timescale 1ns / 100ps

module ecpfpu_checker
   import ecpfpu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_x_one,
   input  logic [15:0] req_y_one,
   input  logic        req_inf_one,
   input  logic [15:0] req_x_two,
   input  logic [15:0] req_y_two,
   input  logic        req_inf_two,
   input  logic [15:0] req_scalar,
   input  logic        rsp_strobe,
   input  logic [15:0] rsp_res_x,
   input  logic [15:0] rsp_res_y,
   input  logic        rsp_res_inf,
   input  logic        rsp_on_curve,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending
);

   typedef struct {
      bit [63:0] x;
      bit [63:0] y;
      bit        inf;
   } ec_point_type;

   typedef struct {
      bit [15:0] x;
      bit [15:0] y;
      bit        inf;
      bit        on_curve;
   } point_word_type;

   bit [63:0] prime;
   bit [63:0] curve_a;
   bit [63:0] curve_b;
   point_word_type expected_points[$];

   function automatic bit [63:0] field_reduce(bit [63:0] v);
      if (prime < 2) begin
         return 0;
      end
      return v % prime;
   endfunction

   function automatic bit [63:0] field_sum(bit [63:0] a, bit [63:0] b);
      bit [63:0] s;
      s = a + b;
      if (s < a || s >= prime) begin
         s = s - prime;
      end
      return s;
   endfunction

   function automatic bit [63:0] field_diff(bit [63:0] a, bit [63:0] b);
      if (a >= b) begin
         return a - b;
      end
      return a + (prime - b);
   endfunction

   function automatic bit [63:0] field_prod(bit [63:0] a, bit [63:0] b);
      bit [63:0] r;
      r = 0;
      for (int i = 63; i >= 0; i--) begin
         r = field_sum(r, r);
         if (b[i]) begin
            r = field_sum(r, a);
         end
      end
      return r;
   endfunction

   function automatic bit [63:0] field_recip(bit [63:0] a);
      bit [63:0] u, v, c0, c1, q, t;
      if (prime < 2) begin
         return 0;
      end
      u = field_reduce(a);
      v = prime;
      c0 = 0;
      c1 = 1;
      while (u > 1 && v != 0) begin
         q = u / v;
         t = v;
         v = u % v;
         u = t;
         t = c0;
         c0 = field_diff(c1, field_prod(q % prime, c0));
         c1 = t;
      end
      return c1;
   endfunction

   function automatic ec_point_type infinity_point();
      ec_point_type r;
      r.x = 0;
      r.y = 0;
      r.inf = 1;
      return r;
   endfunction

   function automatic ec_point_type twice_point(ec_point_type p);
      ec_point_type r;
      bit [63:0] xx, num, lam;
      if (p.inf || p.y == 0) begin
         return infinity_point();
      end
      xx = field_prod(p.x, p.x);
      num = field_sum(field_sum(field_sum(xx, xx), xx), field_reduce(curve_a));
      lam = field_prod(num, field_recip(field_sum(p.y, p.y)));
      r.x = field_diff(field_diff(field_prod(lam, lam), p.x), p.x);
      r.y = field_diff(field_prod(lam, field_diff(p.x, r.x)), p.y);
      r.inf = 0;
      return r;
   endfunction

   function automatic ec_point_type point_sum(ec_point_type p, ec_point_type q);
      ec_point_type r;
      bit [63:0] lam;
      if (p.inf) begin
         return q;
      end
      if (q.inf) begin
         return p;
      end
      if (p.x == q.x && field_sum(p.y, q.y) == 0) begin
         return infinity_point();
      end
      if (p.x == q.x && p.y == q.y) begin
         return twice_point(p);
      end
      lam = field_prod(field_diff(q.y, p.y), field_recip(field_diff(q.x, p.x)));
      r.x = field_diff(field_diff(field_prod(lam, lam), p.x), q.x);
      r.y = field_diff(field_prod(lam, field_diff(p.x, r.x)), p.y);
      r.inf = 0;
      return r;
   endfunction

   function automatic ec_point_type scale_point(bit [63:0] k, ec_point_type g);
      ec_point_type r, t;
      r = infinity_point();
      t = g;
      while (k != 0) begin
         if (k[0]) begin
            r = point_sum(r, t);
         end
         t = twice_point(t);
         k = k >> 1;
      end
      return r;
   endfunction

   function automatic bit curve_holds(ec_point_type p);
      bit [63:0] lhs, rhs;
      if (p.inf) begin
         return 1;
      end
      lhs = field_prod(p.y, p.y);
      rhs = field_sum(field_sum(field_prod(field_prod(p.x, p.x), p.x),
                                field_prod(field_reduce(curve_a), p.x)),
                      field_reduce(curve_b));
      return lhs == rhs;
   endfunction

   function automatic ec_point_type load_point(bit [15:0] x, bit [15:0] y, bit inf);
      ec_point_type p;
      if (inf) begin
         return infinity_point();
      end
      p.x = field_reduce(64'(x));
      p.y = field_reduce(64'(y));
      p.inf = 0;
      return p;
   endfunction

   // Used by the stimulus to walk along a curve of the current setting.
   task automatic multiple_of(input bit [15:0] k, input bit [15:0] x, input bit [15:0] y,
                              input bit inf, output bit [15:0] rx, output bit [15:0] ry,
                              output bit rinf);
      ec_point_type r;
      r = scale_point(64'(k), load_point(x, y, inf));
      rx = r.x[15:0];
      ry = r.y[15:0];
      rinf = r.inf;
   endtask

   function automatic point_word_type compute_result(func_type f, ec_point_type p1,
                                                     ec_point_type p2, bit [15:0] k);
      ec_point_type r;
      point_word_type w;
      r = infinity_point();
      w.on_curve = 0;
      case (f)
         FUNC_ADD: r = point_sum(p1, p2);
         FUNC_DBL: r = twice_point(p1);
         FUNC_MUL: r = scale_point(64'(k), p1);
         default: begin
            w.on_curve = curve_holds(p1);
            r.inf = 0;
         end
      endcase
      if (r.inf) begin
         r.x = 0;
         r.y = 0;
      end
      w.x = r.x[15:0];
      w.y = r.y[15:0];
      w.inf = r.inf;
      return w;
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   assign pending = expected_points.size();

   initial fail_count = 0;

   always @(posedge clock) begin
      point_word_type w;
      if (reset) begin
         prime <= 64'(RESET_MODULUS);
         curve_a <= 64'(RESET_COEF_A);
         curve_b <= 64'(RESET_COEF_B);
      end else begin
         if (start && !busy) begin
            expected_points.push_back(compute_result(func_type'(req_func),
               load_point(req_x_one, req_y_one, req_inf_one),
               load_point(req_x_two, req_y_two, req_inf_two), req_scalar));
         end
         if (rsp_strobe) begin
            if (expected_points.size() == 0) begin
               report("unexpected result word", 1, 0);
            end else begin
               w = expected_points.pop_front();
               if (rsp_res_x !== w.x) report("res_x", rsp_res_x, w.x);
               if (rsp_res_y !== w.y) report("res_y", rsp_res_y, w.y);
               if (rsp_res_inf !== w.inf) report("res_inf", rsp_res_inf, w.inf);
               if (rsp_on_curve !== w.on_curve) report("on_curve", rsp_on_curve, w.on_curve);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MODULUS: prime <= 64'(csr_wdata);
               CSR_COEF_A: curve_a <= 64'(csr_wdata);
               CSR_COEF_B: curve_b <= 64'(csr_wdata);
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/tb.sv =====
// Top of the point unit testbench: clock, reset, command and csr stimulus,
// watchdog and verdict. Depends on ecpfpu_pkg, ecpfpu_checker and the unit itself.
`timescale 1ns / 100ps

module tb;
   import ecpfpu_pkg::*;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_func;
   logic [15:0] req_x_one, req_y_one, req_x_two, req_y_two, req_scalar;
   logic        req_inf_one, req_inf_two;
   logic        rsp_strobe;
   logic [15:0] rsp_res_x, rsp_res_y;
   logic        rsp_res_inf, rsp_on_curve;
   logic        csr_valid, csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   int          fail_count;
   int          pending;
   int          quiet_cycles;
   bit          calm;
   bit [15:0]   prime;
   bit [15:0]   gen_x, gen_y;

   localparam int WATCHDOG_LIMIT = 200000;

   ecc_prime_field_point_unit i_dut (.*);

   ecpfpu_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("ecc_prime_field_point_unit regression: fail");
         $finish;
      end
   end

   task automatic send_command(input func_type f, input bit [15:0] x1, input bit [15:0] y1,
                               input bit i1, input bit [15:0] x2, input bit [15:0] y2,
                               input bit i2, input bit [15:0] k);
      if (!calm && $urandom_range(0, 99) < 15) begin
         start <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start <= 1;
      req_func <= f;
      req_x_one <= x1;
      req_y_one <= y1;
      req_inf_one <= i1;
      req_x_two <= x2;
      req_y_two <= y2;
      req_inf_two <= i2;
      req_scalar <= k;
      forever begin
         @(negedge clock);
         if (!busy) begin
            break;
         end
         @(posedge clock);
      end
      @(posedge clock);
   endtask

   task automatic wait_idle();
      start <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input bit [15:0] value);
      csr_valid <= 1;
      csr_index <= index;
      csr_wdata <= value;
      forever begin
         @(negedge clock);
         if (csr_ready) begin
            break;
         end
         @(posedge clock);
      end
      @(posedge clock);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // Picks a generator, then sets b so that it lies on the curve.
   task automatic setup_curve(input bit [15:0] p, input bit [15:0] a);
      longint lp, la, lx, ly, lb;
      prime = p;
      gen_x = $urandom_range(0, p - 1);
      gen_y = $urandom_range(1, p - 1);
      lp = p;
      la = a % lp;
      lx = gen_x;
      ly = gen_y;
      lb = (ly * ly - (lx * lx % lp) * lx - la * lx) % lp;
      if (lb < 0) lb += lp;
      write_reg(CSR_MODULUS, p);
      write_reg(CSR_COEF_A, a);
      write_reg(CSR_COEF_B, lb[15:0]);
   endtask

   function automatic bit [15:0] pick_scalar();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(0, 15);
      if (r < 95) return $urandom_range(0, 255);
      return $urandom;
   endfunction

   task automatic random_command(input bit on_track);
      bit [15:0] px, py, qx, qy;
      bit pinf, qinf;
      func_type f;
      f = func_type'($urandom_range(0, 3));
      if (on_track && prime >= 3) begin
         i_checker.multiple_of($urandom_range(1, 20), gen_x, gen_y, 0, px, py, pinf);
         case ($urandom_range(0, 3))
            0: begin qx = px; qy = py; qinf = pinf; end
            1: begin qx = px; qy = (py == 0) ? 16'd0 : prime - py; qinf = pinf; end
            default: i_checker.multiple_of($urandom_range(1, 20), gen_x, gen_y, 0,
                                            qx, qy, qinf);
         endcase
         if ($urandom_range(0, 7) == 0 && px <= 16'hffff - prime) px = px + prime;
         if ($urandom_range(0, 7) == 0 && qy <= 16'hffff - prime) qy = qy + prime;
         if ($urandom_range(0, 15) == 0) pinf = 1;
         if ($urandom_range(0, 15) == 0) qinf = 1;
         send_command(f, px, py, pinf, qx, qy, qinf, pick_scalar());
      end else begin
         send_command(f, $urandom, $urandom, $urandom_range(0, 7) == 0, $urandom,
                      $urandom, $urandom_range(0, 7) == 0, pick_scalar());
      end
   endtask

   task automatic random_phase(input int count);
      for (int i = 0; i < count; i++) begin
         random_command($urandom_range(0, 9) < 7);
      end
      wait_idle();
   endtask

   initial begin
      reset = 1;
      start = 0;
      calm = 0;
      req_func = FUNC_ADD;
      req_x_one = 0;
      req_y_one = 0;
      req_inf_one = 0;
      req_x_two = 0;
      req_y_two = 0;
      req_inf_two = 0;
      req_scalar = 0;
      csr_valid = 0;
      csr_index = CSR_MODULUS;
      csr_wdata = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Reset curve y^2 = x^3 + x + 6 over 17; (2, 4) and (2, 13) lie on it.
      prime = 17;
      gen_x = 2;
      gen_y = 4;
      send_command(FUNC_ADD, 2, 4, 0, 2, 13, 0, 0);
      send_command(FUNC_ADD, 2, 4, 0, 2, 4, 0, 0);
      send_command(FUNC_ADD, 2, 4, 1, 5, 6, 0, 0);
      send_command(FUNC_ADD, 2, 4, 0, 5, 6, 1, 0);
      send_command(FUNC_ADD, 2, 4, 1, 5, 6, 1, 0);
      send_command(FUNC_ADD, 2, 4, 0, 2, 7, 0, 0);
      send_command(FUNC_ADD, 16'hffff, 16'hffff, 0, 0, 0, 0, 16'hffff);
      send_command(FUNC_ADD, 3, 6, 0, 2, 4, 0, 0);
      send_command(FUNC_DBL, 2, 4, 0, 0, 0, 0, 0);
      send_command(FUNC_DBL, 5, 0, 0, 0, 0, 0, 0);
      send_command(FUNC_DBL, 5, 17, 0, 0, 0, 0, 0);
      send_command(FUNC_DBL, 2, 4, 1, 0, 0, 0, 0);
      send_command(FUNC_MUL, 2, 4, 0, 0, 0, 0, 0);
      send_command(FUNC_MUL, 2, 4, 0, 0, 0, 0, 1);
      send_command(FUNC_MUL, 2, 4, 0, 0, 0, 0, 19);
      send_command(FUNC_MUL, 2, 4, 0, 0, 0, 0, 16'hffff);
      send_command(FUNC_MUL, 2, 4, 1, 0, 0, 0, 7);
      send_command(FUNC_CHECK, 2, 4, 0, 0, 0, 0, 0);
      send_command(FUNC_CHECK, 2, 5, 0, 0, 0, 0, 0);
      send_command(FUNC_CHECK, 2, 5, 1, 0, 0, 0, 0);
      send_command(FUNC_CHECK, 16'hffff, 16'hffff, 0, 16'hffff, 16'hffff, 1, 0);
      random_phase(30);

      setup_curve(65521, $urandom_range(0, 65520));
      calm = 1;
      random_phase(50);
      calm = 0;

      setup_curve(3, 0);
      random_phase(25);

      setup_curve(65521, 65535);
      random_phase(40);

      setup_curve(251, $urandom);
      random_phase(40);

      setup_curve(65535, 65535);
      random_phase(25);

      prime = 0;
      write_reg(CSR_MODULUS, 0);
      write_reg(CSR_COEF_A, 16'hffff);
      write_reg(CSR_COEF_B, 16'hffff);
      random_phase(15);

      prime = 1;
      write_reg(CSR_MODULUS, 1);
      write_reg(CSR_COEF_B, 0);
      random_phase(10);

      setup_curve(65521, 0);
      random_phase(40);

      if (fail_count == 0) begin
         $display("ecc_prime_field_point_unit regression: pass");
      end else begin
         $display("ecc_prime_field_point_unit regression: fail");
      end
      $finish;
   end

endmodule
